>>> design/assert_macros.svh
// Assertion macros for the port-level checker of the shift core.
// No dependencies; the user supplies the clock and reset names where needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a reset that masks the check.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("shift core assertion failed");

// Same, on the usual clock and reset names of this project.
`define ASSERT_STD(lbl, prop) \
   `ASSERT_CLK(lbl, clock, reset, prop)

`endif

>>> design/ctts_pkg.sv
// Shared types and constants for the circular three-tap shift core.
// No dependencies; every module of the core imports this package.
package ctts_pkg;

   localparam int SLOTS_MAX = 64;
   localparam int DATA_W    = 16;
   localparam int SLOT_W    = 6;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int FRAC_W    = 14;
   localparam int Q_W       = SUM_W - FRAC_W;

   localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(8192);
   localparam logic signed [DATA_W-1:0] VAL_MAX    = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN    = 16'sh8000;

   typedef struct packed {
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] shift_back;
      logic signed [DATA_W-1:0] shift_stay;
      logic signed [DATA_W-1:0] shift_fwd;
      logic                     row_end;
   } ctts_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [SLOT_W-1:0]        slot;
      logic                     clipped;
      logic                     final_res;
   } ctts_rsp_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } ctts_state_type;

   // One slot handed from the sequencer to the datapath.
   typedef struct packed {
      logic              vld;
      logic              has_next;
      logic              final_slot;
      logic [SLOT_W-1:0] slot;
   } ctts_issue_type;

   // Per-row context latched while the row loads.
   typedef struct packed {
      logic signed [DATA_W-1:0] tap_back;
      logic signed [DATA_W-1:0] tap_stay;
      logic signed [DATA_W-1:0] tap_fwd;
      logic signed [DATA_W-1:0] first_w;
      logic signed [DATA_W-1:0] last_w;
   } ctts_ctx_type;

endpackage

>>> design/ctts_row_mem.sv
// Row storage: one write port, one read port with registered read data.
// Depends on ctts_pkg for the data width.
module ctts_row_mem
   import ctts_pkg::*;
#(
   parameter int ADDR_W = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ctts_ctrl.sv
// Load and emit sequencer: writes row words into the memory, latches the taps,
// then walks the slots and issues one memory read per slot. Uses ctts_pkg.
module ctts_ctrl
   import ctts_pkg::*;
#(
   parameter int MAX_SLOTS = SLOTS_MAX,
   parameter int ADDR_W    = 6,
   parameter int CNT_W     = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  ctts_req_type             req_word,
   input  logic                     dp_busy,
   output logic                     busy,
   output logic                     mem_wr_en,
   output logic [ADDR_W-1:0]        mem_wr_addr,
   output logic signed [DATA_W-1:0] mem_wr_data,
   output logic [ADDR_W-1:0]        mem_rd_addr,
   output ctts_issue_type           issue,
   output ctts_ctx_type             ctx
);

   ctts_state_type   state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   ctts_ctx_type     ctx_ff, ctx_in;

   logic             accept;
   logic             row_done;
   logic [CNT_W-1:0] fill_plus;
   logic [CNT_W-1:0] idx_plus;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      len_ff <= len_in;
      idx_ff <= idx_in;
      ctx_ff <= ctx_in;
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      ctx_in      = ctx_ff;
      busy        = (state_ff == ST_EMIT) || dp_busy;
      accept      = start && !busy;
      fill_plus   = fill_ff + CNT_W'(1);
      idx_plus    = idx_ff + CNT_W'(1);
      row_done    = req_word.row_end || (fill_plus == CNT_W'(MAX_SLOTS));
      mem_wr_en   = 1'b0;
      mem_wr_addr = fill_ff[ADDR_W-1:0];
      mem_wr_data = req_word.weight;
      // Slot i needs word i+1 as its forward neighbor; the wrap uses first_w.
      mem_rd_addr = idx_plus[ADDR_W-1:0];
      issue       = '0;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               mem_wr_en     = 1'b1;
               ctx_in.last_w = req_word.weight;
               if (fill_ff == '0) begin
                  ctx_in.tap_back = req_word.shift_back;
                  ctx_in.tap_stay = req_word.shift_stay;
                  ctx_in.tap_fwd  = req_word.shift_fwd;
                  ctx_in.first_w  = req_word.weight;
               end
               if (row_done) begin
                  len_in   = fill_plus;
                  fill_in  = '0;
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  fill_in = fill_plus;
               end
            end
         end
         ST_EMIT: begin
            issue.vld        = 1'b1;
            issue.slot       = SLOT_W'(idx_ff);
            issue.has_next   = (idx_plus != len_ff);
            issue.final_slot = (idx_plus == len_ff);
            idx_in           = idx_plus;
            if (idx_plus == len_ff) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign ctx = ctx_ff;

endmodule

>>> design/ctts_dp.sv
// Datapath: three-word sliding window, three multipliers, then the rounded
// and saturated sum into the result register. Uses ctts_pkg.
module ctts_dp
   import ctts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctts_issue_type           issue,
   input  ctts_ctx_type             ctx,
   input  logic signed [DATA_W-1:0] rd_data,
   output logic                     busy,
   output logic                     strobe,
   output ctts_rsp_type             rsp_word
);

   ctts_issue_type           b_issue_ff;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] prev_sel, cur_sel, next_sel;
   logic signed [PROD_W-1:0] prod_back_in, prod_stay_in, prod_fwd_in;
   logic signed [PROD_W-1:0] prod_back_ff, prod_stay_ff, prod_fwd_ff;
   logic                     c_vld_ff;
   logic [SLOT_W-1:0]        c_slot_ff;
   logic                     c_final_ff;
   logic signed [SUM_W-1:0]  sum_rnd;
   logic signed [Q_W-1:0]    q_val;
   logic                     clip_hi, clip_lo;
   ctts_rsp_type             rsp_in, rsp_ff;
   logic                     strobe_ff;

   // Slot 0 starts the window from the latched last and first words.
   always_comb begin
      prev_sel     = (b_issue_ff.slot == '0) ? ctx.last_w  : prev_ff;
      cur_sel      = (b_issue_ff.slot == '0) ? ctx.first_w : cur_ff;
      next_sel     = b_issue_ff.has_next ? rd_data : ctx.first_w;
      prev_in      = cur_sel;
      cur_in       = next_sel;
      prod_back_in = ctx.tap_back * prev_sel;
      prod_stay_in = ctx.tap_stay * cur_sel;
      prod_fwd_in  = ctx.tap_fwd  * next_sel;
   end

   always_comb begin
      sum_rnd = SUM_W'(prod_back_ff) + SUM_W'(prod_stay_ff) + SUM_W'(prod_fwd_ff)
              + ROUND_HALF;
      q_val   = sum_rnd[SUM_W-1:FRAC_W];
      clip_hi = !q_val[Q_W-1] && (q_val[Q_W-2:DATA_W-1] != '0);
      clip_lo =  q_val[Q_W-1] && (q_val[Q_W-2:DATA_W-1] != '1);
      rsp_in.slot      = c_slot_ff;
      rsp_in.final_res = c_final_ff;
      rsp_in.clipped   = clip_hi || clip_lo;
      if (clip_hi) begin
         rsp_in.value = VAL_MAX;
      end else if (clip_lo) begin
         rsp_in.value = VAL_MIN;
      end else begin
         rsp_in.value = q_val[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_issue_ff <= '0;
         c_vld_ff   <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         b_issue_ff <= issue;
         c_vld_ff   <= b_issue_ff.vld;
         strobe_ff  <= c_vld_ff;
      end
      if (b_issue_ff.vld) begin
         prev_ff <= prev_in;
         cur_ff  <= cur_in;
      end
      prod_back_ff <= prod_back_in;
      prod_stay_ff <= prod_stay_in;
      prod_fwd_ff  <= prod_fwd_in;
      c_slot_ff    <= b_issue_ff.slot;
      c_final_ff   <= b_issue_ff.final_slot;
      rsp_ff       <= rsp_in;
   end

   assign busy     = b_issue_ff.vld || c_vld_ff;
   assign strobe   = strobe_ff;
   assign rsp_word = rsp_ff;

endmodule

>>> design/circular_three_tap_shift_core.sv
// Circular three-tap shift core. A row of n words loads at one word per cycle
// while busy is low. After the row-ending word is accepted, busy rises and the
// slots show on the result ports in order, slot 0 first, then one slot per
// cycle, paced by the single read port of the row memory. Busy falls as the
// final slot shows. Synchronous reset returns the core to an empty row.
module circular_three_tap_shift_core
   import ctts_pkg::*;
#(
   parameter int MAX_SLOTS = SLOTS_MAX
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ctts_req_type req_word,
   output logic         strobe,
   output ctts_rsp_type rsp_word
);

   localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   logic                     dp_busy;
   logic                     mem_wr_en;
   logic [ADDR_W-1:0]        mem_wr_addr;
   logic signed [DATA_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0]        mem_rd_addr;
   logic signed [DATA_W-1:0] mem_rd_data;
   ctts_issue_type           issue;
   ctts_ctx_type             ctx;

   ctts_ctrl #(
      .MAX_SLOTS (MAX_SLOTS),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_word    (req_word),
      .dp_busy     (dp_busy),
      .busy        (busy),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .issue       (issue),
      .ctx         (ctx)
   );

   ctts_row_mem #(
      .ADDR_W (ADDR_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ctts_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .ctx      (ctx),
      .rd_data  (mem_rd_data),
      .busy     (dp_busy),
      .strobe   (strobe),
      .rsp_word (rsp_word)
   );

endmodule

>>> design/ctts_checker.sv
// Port-level checks for the shift core, attached to the top level by bind.
// Depends on ctts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctts_checker
   import ctts_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input ctts_req_type req_word,
   input logic         strobe,
   input ctts_rsp_type rsp_word
);

   logic              mid_row;
   logic [SLOT_W-1:0] slot_plus;
   logic              at_limit;

   assign mid_row   = strobe && !rsp_word.final_res;
   assign slot_plus = rsp_word.slot + SLOT_W'(1);
   assign at_limit  = (rsp_word.value == VAL_MAX) || (rsp_word.value == VAL_MIN);

   // A row-ending word always starts an unload.
   `ASSERT_STD(a_row_end_busy, start && !busy && req_word.row_end |=> busy)

   // The last word of a row is never followed at once by another word.
   `ASSERT_STD(a_final_gap, strobe && rsp_word.final_res |=> !strobe)

   // Slots of one row leave back to back and in order.
   `ASSERT_STD(a_slot_order, mid_row |=> strobe && (rsp_word.slot == $past(slot_plus)))

   // Busy drops exactly when the final word of a row shows.
   `ASSERT_STD(a_busy_fall, $fell(busy) |-> strobe && rsp_word.final_res)

   // A saturated word sits on one of the range limits.
   `ASSERT_STD(a_clip_value, strobe && rsp_word.clipped |-> at_limit)

endmodule

bind circular_three_tap_shift_core ctts_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_word (req_word),
   .strobe   (strobe),
   .rsp_word (rsp_word)
);

>>> dv/ctts_slot_checker.sv
// Checker for the circular three-tap shift core: mirrors the row, predicts every slot.
// Depends on ctts_pkg for the word types and the Q2.14 limits.
module ctts_slot_checker
   import ctts_pkg::*;
#(
   parameter int MAX_SLOTS = SLOTS_MAX
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  ctts_req_type req_word,
   input  logic         strobe,
   input  ctts_rsp_type rsp_word,
   output int           mismatches,
   output int           outstanding
);

   localparam int REPORT_MAX = 10;

   logic signed [DATA_W-1:0] row_words [SLOTS_MAX];
   int                       row_len;
   logic signed [DATA_W-1:0] tap_back;
   logic signed [DATA_W-1:0] tap_stay;
   logic signed [DATA_W-1:0] tap_fwd;
   ctts_rsp_type             due_slots [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Every slot of the finished row, in index order, with wrap at both ends.
   task automatic unload_row();
      int           prev;
      int           next;
      longint       acc;
      longint       q;
      ctts_rsp_type r;
      for (int i = 0; i < row_len; i++) begin
         prev = (i == 0) ? row_len - 1 : i - 1;
         next = (i == row_len - 1) ? 0 : i + 1;
         acc = longint'(tap_back) * longint'(row_words[prev])
             + longint'(tap_stay) * longint'(row_words[i])
             + longint'(tap_fwd) * longint'(row_words[next]);
         // Round half up: add half an LSB, then an arithmetic shift floors.
         q = (acc + 64'sd8192) >>> FRAC_W;
         r.clipped = 1'b1;
         if (q > 32767) begin
            r.value = VAL_MAX;
         end else if (q < -32768) begin
            r.value = VAL_MIN;
         end else begin
            r.value   = DATA_W'(q);
            r.clipped = 1'b0;
         end
         r.slot      = SLOT_W'(i);
         r.final_res = (i == row_len - 1);
         due_slots.push_back(r);
      end
      row_len = 0;
   endtask

   task automatic load_word(input ctts_req_type w);
      if (row_len == 0) begin
         tap_back = w.shift_back;
         tap_stay = w.shift_stay;
         tap_fwd  = w.shift_fwd;
      end
      row_words[row_len] = w.weight;
      row_len++;
      if (w.row_end || row_len == MAX_SLOTS) begin
         unload_row();
      end
   endtask

   task automatic check_slot(input ctts_rsp_type got);
      ctts_rsp_type want;
      if (due_slots.size() == 0) begin
         if (mismatches < REPORT_MAX) begin
            $display("unexpected result word: value %0d slot %0d clipped %0b last %0b",
                     got.value, got.slot, got.clipped, got.final_res);
         end
         mismatches++;
      end else begin
         want = due_slots.pop_front();
         if (got.value !== want.value || got.slot !== want.slot ||
             got.clipped !== want.clipped || got.final_res !== want.final_res) begin
            if (mismatches < REPORT_MAX) begin
               $display("slot mismatch: want value %0d slot %0d clipped %0b last %0b",
                        want.value, want.slot, want.clipped, want.final_res);
               $display("               got  value %0d slot %0d clipped %0b last %0b",
                        got.value, got.slot, got.clipped, got.final_res);
            end
            mismatches++;
         end
      end
   endtask

   // Sampling at the edge sees the values from before it, so results are retired
   // before a word accepted at the same edge adds new ones.
   always @(posedge clock) begin
      if (reset) begin
         row_len  = 0;
         tap_back = '0;
         tap_stay = '0;
         tap_fwd  = '0;
         due_slots.delete();
      end else begin
         if (strobe) begin
            check_slot(rsp_word);
         end
         if (start && !busy) begin
            load_word(req_word);
         end
      end
      outstanding = due_slots.size();
   end

endmodule

>>> dv/circular_three_tap_shift_core_tb.sv
// Top of the shift core regression: clock, reset, directed and random rows.
// Depends on ctts_pkg, the core and ctts_slot_checker, which checks every result slot.
module circular_three_tap_shift_core_tb;
   import ctts_pkg::*;

   localparam int PHASE_WORDS = 120;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   ctts_req_type req_word = '0;
   logic         busy;
   logic         strobe;
   ctts_rsp_type rsp_word;
   int           mismatch_count;
   int           pending_slots;
   int           idle_pct   = 0;
   int           words_sent = 0;

   always #5 clock = ~clock;

   circular_three_tap_shift_core #(.MAX_SLOTS(SLOTS_MAX)) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .strobe   (strobe),
      .rsp_word (rsp_word)
   );

   ctts_slot_checker #(.MAX_SLOTS(SLOTS_MAX)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .strobe      (strobe),
      .rsp_word    (rsp_word),
      .mismatches  (mismatch_count),
      .outstanding (pending_slots)
   );

   // Start stays high from one word to the next unless a gap is drawn.
   task automatic send_word(input ctts_req_type w);
      int gap;
      gap = 0;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_item(input logic [15:0] w, input logic [15:0] sb,
                            input logic [15:0] ss, input logic [15:0] sf,
                            input logic last);
      ctts_req_type item;
      item.weight     = w;
      item.shift_back = sb;
      item.shift_stay = ss;
      item.shift_fwd  = sf;
      item.row_end    = last;
      send_word(item);
   endtask

   // Extremes and moderate values are favored so that unclipped sums stay common.
   function automatic logic [15:0] pick_q14();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3, 4, 5, 6: return 16'($urandom_range(16383)) - 16'd8192;
         default: return 16'($urandom);
      endcase
   endfunction

   // A full-length row may close on its own, without the row_end flag.
   task automatic send_row(input int n, input logic close);
      for (int i = 0; i < n; i++) begin
         send_item(pick_q14(), pick_q14(), pick_q14(), pick_q14(),
                   (i == n - 1) ? close : 1'b0);
      end
   endtask

   initial begin
      int idle_plan [4];
      int phase_words;
      int pick;
      idle_plan = '{0, 49, 0, 30};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-word rows: both saturation directions and rounding of exact halves.
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_item(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
      send_item(16'h0001, 16'h0000, 16'h2000, 16'h0000, 1'b1);
      send_item(16'hFFFF, 16'h0000, 16'h2000, 16'h0000, 1'b1);
      // Short rows; shift fields on later words carry junk that must be ignored.
      send_item(16'h4000, 16'h1000, 16'h2000, 16'h3000, 1'b0);
      send_item(16'hC000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
      send_item(16'h8000, 16'h4000, 16'h0000, 16'hC000, 1'b0);
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      send_item(16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_item(16'h1234, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_item(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_item(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_item(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(16'hFFFF, 16'h0000, 16'h0000, 16'h2000, 1'b0);
      send_item(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_item(16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_item(16'hC000, 16'h0000, 16'h0000, 16'h0000, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct    = idle_plan[phase];
         phase_words = words_sent;
         while (words_sent - phase_words < PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
               send_row(SLOTS_MAX, 1'($urandom_range(1)));
            end else if (pick < 15) begin
               send_row($urandom_range(20, 9), 1'b1);
            end else begin
               send_row($urandom_range(8, 1), 1'b1);
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_slots != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("circular_three_tap_shift_core regression: pass");
      end else begin
         $display("circular_three_tap_shift_core regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("circular_three_tap_shift_core regression: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/ctts_pkg.sv
design/ctts_row_mem.sv
design/ctts_ctrl.sv
design/ctts_dp.sv
design/circular_three_tap_shift_core.sv
design/ctts_checker.sv
dv/ctts_slot_checker.sv
dv/circular_three_tap_shift_core_tb.sv
